### src/sbus_frame_decoder_unit_macros.svh
// Assertion macros used by the frame decoder's unpack module.
`ifndef SBUS_FRAME_DECODER_UNIT_MACROS_SVH
`define SBUS_FRAME_DECODER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SBUSFD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SBUSFD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sbusfd_pkg.sv
package sbusfd_pkg;

  localparam int FrameBytes = 25;
  localparam int StoreBits  = 8 * (FrameBytes - 1);
  localparam int FlagsLsb   = 8 * (FrameBytes - 2);
  localparam int ChanLsb    = 8;
  localparam int PosW       = 5;
  localparam int ChanW      = 11;
  localparam int AmtW       = 8;
  localparam int IdxW       = 5;
  localparam int LinkW      = 2;
  localparam int NumProp    = 16;
  localparam int NumChan    = 18;

  localparam logic [7:0] HeaderByte = 8'h0F;
  localparam logic [7:0] FooterByte = 8'h00;

  localparam logic [ChanW-1:0] ThrReset = 11'd992;
  localparam logic [AmtW-1:0]  AmtReset = 8'd128;

  typedef enum logic [LinkW-1:0] {
    LINK_OK       = 2'd0,
    LINK_LOST     = 2'd1,
    LINK_FAILSAFE = 2'd2
  } link_e;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_AMOUNT    = 1'b1
  } reg_e;

  // Status from the frame store towards the unpacker.
  typedef struct packed {
    logic       ok;
    logic [1:0] link_flags;
    logic       bit_lo;
    logic       bit_hi;
  } col_t;

endpackage

### src/sbus_frame_decoder_unit.sv
// Frame decoder for a serial radio-control link carrying sixteen proportional channels.
// Input channel: one received byte per transaction, with frame_start_i high on the first
// byte after an idle gap. A frame is 25 bytes; bytes beyond the 25th are ignored until the
// next start mark, and a start mark in mid-frame restarts collection.
// On the 25th byte a frame with the correct header and footer produces 18 output
// transactions: channels 0 to 15 in order, then the two digital channels, the last marked
// by last_of_frame_o. A frame with a bad header or footer produces nothing.
// Channels are extracted one bit per cycle from the frame shift register, subject to the
// output stall described below; each proportional result is registered in the output once
// all eleven bits of its channel have been shifted in.
// Input bytes are accepted while in_stall_o is low; in_stall_o is high while a frame is being unpacked.
// A stall on the output holds the current result; extraction of the next one stops at its last bit.
// Reset clears the control state and returns the registers to threshold 992, amount 128;
// the decoder then waits for a start mark. Registers are at byte addresses 0 and 4.
module sbus_frame_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             frame_start_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sbusfd_pkg::IdxW-1:0]      channel_index_o,
  output logic [sbusfd_pkg::ChanW-1:0]     channel_value_o,
  output logic [sbusfd_pkg::LinkW-1:0]     link_status_o,
  output logic                             last_of_frame_o
);
  import sbusfd_pkg::*;

  logic [ChanW-1:0] thr_q;
  logic [AmtW-1:0]  amt_q;
  logic             cfg_wr;
  reg_e             reg_sel;
  logic             in_accept;
  logic             shift;
  logic             busy;
  col_t             col;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      amt_q <= AmtReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_THRESHOLD: thr_q <= pwdata[ChanW-1:0];
        REG_AMOUNT:    amt_q <= pwdata[AmtW-1:0];
        default:       thr_q <= thr_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = 32'(thr_q);
      REG_AMOUNT:    prdata = 32'(amt_q);
      default:       prdata = '0;
    endcase
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  sbusfd_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .shift_i       (shift),
    .col_o         (col)
  );

  sbusfd_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .col_i           (col),
    .thr_i           (thr_q),
    .amt_i           (amt_q),
    .shift_o         (shift),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .link_status_o   (link_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

### src/sbusfd_collect.sv
module sbusfd_collect (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  input  logic                  shift_i,
  output sbusfd_pkg::col_t      col_o
);
  import sbusfd_pkg::*;

  localparam logic [PosW-1:0] PosIdle = PosW'(FrameBytes);
  localparam logic [PosW-1:0] PosLast = PosW'(FrameBytes - 1);

  logic [PosW-1:0]      pos_q, pos_d, pos_eff;
  logic                 ok_q, ok_d;
  logic                 store_en;
  logic [StoreBits-1:0] frame_q;

  always_comb begin
    pos_eff  = frame_start_i ? '0 : pos_q;
    pos_d    = pos_q;
    ok_d     = 1'b0;
    store_en = 1'b0;
    if (in_accept_i && (pos_eff != PosIdle)) begin
      if (pos_eff == PosLast) begin
        pos_d = PosIdle;
        ok_d  = (frame_q[7:0] == HeaderByte) && (rx_byte_i == FooterByte);
      end else begin
        pos_d    = pos_eff + PosW'(1);
        store_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
      ok_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ok_q  <= ok_d;
    end
  end

  // Bytes enter at the top, so byte 0 sits at the bottom once the frame is complete.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q <= {rx_byte_i, frame_q[StoreBits-1:8]};
    end else if (shift_i) begin
      frame_q <= {1'b0, frame_q[StoreBits-1:1]};
    end
  end

  assign col_o.ok         = ok_q;
  assign col_o.link_flags = frame_q[FlagsLsb+3:FlagsLsb+2];
  assign col_o.bit_lo     = frame_q[ChanLsb];
  assign col_o.bit_hi     = frame_q[ChanLsb+1];

endmodule

### src/sbusfd_unpack.sv
`include "sbus_frame_decoder_unit_macros.svh"

module sbusfd_unpack (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbusfd_pkg::col_t                 col_i,
  input  logic [sbusfd_pkg::ChanW-1:0]     thr_i,
  input  logic [sbusfd_pkg::AmtW-1:0]      amt_i,
  output logic                             shift_o,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sbusfd_pkg::IdxW-1:0]      channel_index_o,
  output logic [sbusfd_pkg::ChanW-1:0]     channel_value_o,
  output logic [sbusfd_pkg::LinkW-1:0]     link_status_o,
  output logic                             last_of_frame_o
);
  import sbusfd_pkg::*;

  localparam int BitW = $clog2(ChanW);
  localparam logic [BitW-1:0] LastBit  = BitW'(ChanW - 1);
  localparam logic [IdxW-1:0] LastProp = IdxW'(NumProp - 1);
  localparam logic [IdxW-1:0] FirstDig = IdxW'(NumProp);
  localparam logic [IdxW-1:0] LastDig  = IdxW'(NumChan - 1);
  localparam logic [ChanW-1:0] ChanMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIGI
  } state_e;

  state_e           state_q;
  logic [BitW-1:0]  bit_q;
  logic [IdxW-1:0]  chan_q;
  logic [ChanW-1:0] acc_q, acc_d;
  link_e            link_q, link_d;
  logic             out_free;
  logic [ChanW:0]   sum;
  logic [ChanW-1:0] adj_val;

  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_index_q;
  logic [ChanW-1:0] out_value_q;
  link_e            out_link_q;
  logic             out_last_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign shift_o  = (state_q == ST_SHIFT) && ((bit_q != LastBit) || out_free);
  assign busy_o   = (state_q != ST_IDLE) || col_i.ok;
  assign acc_d    = {col_i.bit_lo, acc_q[ChanW-1:1]};

  assign out_valid_d = (shift_o && (bit_q == LastBit)) ||
                       ((state_q == ST_DIGI) && out_free) ||
                       (out_valid_q && out_stall_i);

  always_comb begin
    sum     = {1'b0, acc_d} + (ChanW+1)'(amt_i);
    adj_val = acc_d;
    if ((chan_q == '0) && (acc_d < thr_i)) begin
      adj_val = sum[ChanW] ? ChanMax : sum[ChanW-1:0];
    end
    if (col_i.link_flags[1]) begin
      link_d = LINK_FAILSAFE;
    end else if (col_i.link_flags[0]) begin
      link_d = LINK_LOST;
    end else begin
      link_d = LINK_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      chan_q      <= '0;
      acc_q       <= '0;
      link_q      <= LINK_OK;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_value_q <= '0;
      out_link_q  <= LINK_OK;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (col_i.ok) begin
            link_q  <= link_d;
            bit_q   <= '0;
            chan_q  <= '0;
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (shift_o) begin
            acc_q <= acc_d;
            if (bit_q == LastBit) begin
              bit_q       <= '0;
              out_index_q <= chan_q;
              out_value_q <= adj_val;
              out_link_q  <= link_q;
              out_last_q  <= 1'b0;
              chan_q      <= chan_q + IdxW'(1);
              if (chan_q == LastProp) begin
                state_q <= ST_DIGI;
              end
            end else begin
              bit_q <= bit_q + BitW'(1);
            end
          end
        end
        ST_DIGI: begin
          if (out_free) begin
            out_index_q <= chan_q;
            out_value_q <= ChanW'((chan_q == FirstDig) ? col_i.bit_lo : col_i.bit_hi);
            out_link_q  <= link_q;
            out_last_q  <= (chan_q == LastDig);
            chan_q      <= chan_q + IdxW'(1);
            if (chan_q == LastDig) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_index_q;
  assign channel_value_o = out_value_q;
  assign link_status_o   = out_link_q;
  assign last_of_frame_o = out_last_q;

  `SBUSFD_ASSERT_IMP(a_ok_when_idle, clk_i, rst_ni, col_i.ok, state_q == ST_IDLE, "early frame")
  `SBUSFD_ASSERT_IMP(a_last_index, clk_i, rst_ni, out_last_q, out_index_q == LastDig, "bad last")
  `SBUSFD_ASSERT_IMP(a_digi, clk_i, rst_ni, state_q == ST_DIGI, chan_q >= FirstDig, "digi range")
  `SBUSFD_ASSERT_NXT(a_ok_starts, clk_i, rst_ni, col_i.ok, state_q == ST_SHIFT, "no start")

endmodule
